### rtl/hme_pkg.sv
// ----------------------------------------------------------------------------
// hme_pkg
// Shared constants, item types and control structs of the histogram engine.
// ----------------------------------------------------------------------------
package hme_pkg;

  localparam int COUNT_DEPTH  = 4096;
  localparam int LEVELS       = 256;
  localparam int MAX_CHANNELS = 3;

  localparam int CNT_AW = $clog2(COUNT_DEPTH);
  localparam int LVL_AW = $clog2(LEVELS);
  localparam int OFS_W  = 13;
  localparam int SUM_W  = 14;
  localparam int CFG_AW = 3;

  localparam logic REG_CHANNELS_USED = 1'b0;

  typedef enum logic [1:0] {
    OP_PIXEL      = 2'd0,
    OP_MAP_WRITE  = 2'd1,
    OP_READ       = 2'd2,
    OP_READ_CLEAR = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_UPDATE
  } hme_state_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  sample0;
    logic [7:0]  sample1;
    logic [7:0]  sample2;
    logic        pixel_enable;
    logic [1:0]  map_channel;
    logic [7:0]  map_level;
    logic [12:0] map_offset;
    logic [11:0] bin_address;
  } in_item_t;

  typedef struct packed {
    logic [31:0] count_value;
    logic        pixel_counted;
  } out_result_t;

  // merged lookup of the active lanes
  typedef struct packed {
    logic              hit;
    logic [CNT_AW-1:0] addr;
  } merge_res_t;

  // request into the count store
  typedef struct packed {
    logic              valid;
    logic [1:0]        op;
    logic              ok;
    logic [CNT_AW-1:0] addr;
  } cnt_req_t;

endpackage

### rtl/hme_lane.sv
// ----------------------------------------------------------------------------
// hme_lane
// Bin map of one channel: one entry per level, registered lookup.
// ----------------------------------------------------------------------------
module hme_lane
  import hme_pkg::*;
(
  input  logic              clk,
  input  logic              wr_en,
  input  logic [LVL_AW-1:0] wr_level,
  input  logic [OFS_W-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [LVL_AW-1:0] rd_level,
  output logic [OFS_W-1:0]  rd_data
);

  logic [OFS_W-1:0] map_mem [LEVELS];
  logic [OFS_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      map_mem[wr_level] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= map_mem[rd_level];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/hme_merge.sv
// ----------------------------------------------------------------------------
// hme_merge
// Combines the lane lookups into one count store address and a hit flag.
// ----------------------------------------------------------------------------
module hme_merge
  import hme_pkg::*;
(
  input  logic [OFS_W-1:0] lane_data [MAX_CHANNELS],
  input  logic [1:0]       channels_used,
  output merge_res_t       merged
);

  logic [1:0]       n_act;
  logic             mark;
  logic [SUM_W-1:0] sum;

  always_comb begin
    n_act = channels_used;
    if (n_act == 2'd0) begin
      n_act = 2'd1;
    end
    if (32'(n_act) > 32'(MAX_CHANNELS)) begin
      n_act = 2'(MAX_CHANNELS);
    end
    mark = 1'b0;
    sum  = '0;
    for (int c = 0; c < MAX_CHANNELS; c++) begin
      if (c < int'(n_act)) begin
        // top bit of an entry marks the level out of range
        mark = mark | lane_data[c][OFS_W-1];
        sum  = sum + SUM_W'(lane_data[c][OFS_W-2:0]);
      end
    end
    merged.hit  = !mark && (32'(sum) < 32'(COUNT_DEPTH));
    merged.addr = CNT_AW'(sum);
  end

endmodule

### rtl/hme_count.sv
// ----------------------------------------------------------------------------
// hme_count
// Count store with read-modify-write update, read-and-clear and reset sweep.
// ----------------------------------------------------------------------------
module hme_count
  import hme_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cnt_req_t          req,
  input  logic              clr_en,
  input  logic [CNT_AW-1:0] clr_addr,
  output logic              res_valid,
  output out_result_t       res
);

  logic [31:0]       cnt_mem [COUNT_DEPTH];
  logic [31:0]       rd_data_r;
  cnt_req_t          stage_r;
  logic              res_valid_r;
  out_result_t       res_r;

  logic              we;
  logic [CNT_AW-1:0] waddr;
  logic [31:0]       wdata;
  logic              counted;
  logic [31:0]       value;

  always_comb begin
    counted = stage_r.valid && (stage_r.op == OP_PIXEL) && stage_r.ok &&
              (rd_data_r != '1);
    value   = '0;
    if (stage_r.valid && stage_r.ok &&
        ((stage_r.op == OP_READ) || (stage_r.op == OP_READ_CLEAR))) begin
      value = rd_data_r;
    end
    we    = 1'b0;
    waddr = stage_r.addr;
    wdata = '0;
    if (clr_en) begin
      we    = 1'b1;
      waddr = clr_addr;
    end else if (counted) begin
      we    = 1'b1;
      wdata = rd_data_r + 32'd1;
    end else if (stage_r.valid && stage_r.ok && (stage_r.op == OP_READ_CLEAR)) begin
      we    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      cnt_mem[waddr] <= wdata;
    end
    if (req.valid) begin
      rd_data_r <= cnt_mem[req.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r     <= '0;
      res_valid_r <= 1'b0;
    end else begin
      stage_r     <= req;
      res_valid_r <= stage_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    res_r.count_value   <= value;
    res_r.pixel_counted <= counted;
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

### rtl/multichannel_histogram_engine_core.sv
// ----------------------------------------------------------------------------
// multichannel_histogram_engine_core
// Histogram of 8-bit pixels over up to three channels with loadable bin maps.
// ----------------------------------------------------------------------------
// After reset the block sweeps the count store to zero, one count a cycle, and
// busy stays high until the sweep is done and the first item can be taken. An
// item then takes a lookup step for the per-channel bin map lookups, which run
// in parallel lanes, and an update step for the read-modify-write of the single
// count store port. A new item is accepted in a cycle in which busy is low, so
// the next item can be taken during the update step of the last. Each item
// gives exactly one result on out_valid; the receiver cannot stall it.
module multichannel_histogram_engine_core
  import hme_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  in_item_t          in_item,
  output logic              out_valid,
  output out_result_t       out_result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  hme_state_t        state_r, state_nxt;
  logic [CNT_AW-1:0] clr_addr_r, clr_addr_nxt;
  logic [1:0]        channels_used_r;
  logic [1:0]        op_r;
  logic              pen_r;
  logic [11:0]       baddr_r;

  logic              accept;
  logic              cfg_wr;
  logic              clr_done;
  logic [7:0]        samples [3];
  logic [OFS_W-1:0]  lane_data [MAX_CHANNELS];
  merge_res_t        merged;
  cnt_req_t          req;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      channels_used_r <= 2'd1;
    end else if (cfg_wr && (paddr[2] == REG_CHANNELS_USED)) begin
      channels_used_r <= pwdata[1:0];
    end
  end

  assign prdata = (paddr[2] == REG_CHANNELS_USED) ? {30'd0, channels_used_r} : 32'd0;

  // sequencer
  assign busy     = (state_r == ST_CLEAR) || (state_r == ST_LOOKUP);
  assign accept   = start && !busy;
  assign clr_done = (clr_addr_r == CNT_AW'(COUNT_DEPTH - 1));

  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    unique case (state_r)
      ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        state_nxt = accept ? ST_LOOKUP : ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_addr_r <= '0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= in_item.opcode;
      pen_r   <= in_item.pixel_enable;
      baddr_r <= in_item.bin_address;
    end
  end

  // one bin map lane per channel
  assign samples[0] = in_item.sample0;
  assign samples[1] = in_item.sample1;
  assign samples[2] = in_item.sample2;

  for (genvar c = 0; c < MAX_CHANNELS; c++) begin : g_lane
    hme_lane u_lane (
      .clk      (clk),
      .wr_en    (accept && (in_item.opcode == OP_MAP_WRITE) &&
                 (in_item.map_channel == 2'(c))),
      .wr_level (in_item.map_level),
      .wr_data  (in_item.map_offset),
      .rd_en    (accept && (in_item.opcode == OP_PIXEL)),
      .rd_level (samples[c]),
      .rd_data  (lane_data[c])
    );
  end

  hme_merge u_merge (
    .lane_data     (lane_data),
    .channels_used (channels_used_r),
    .merged        (merged)
  );

  always_comb begin
    req.valid = (state_r == ST_LOOKUP);
    req.op    = op_r;
    req.ok    = 1'b0;
    req.addr  = '0;
    unique case (op_r)
      OP_PIXEL: begin
        req.ok   = pen_r && merged.hit;
        req.addr = merged.addr;
      end
      OP_READ, OP_READ_CLEAR: begin
        req.ok   = 32'(baddr_r) < 32'(COUNT_DEPTH);
        req.addr = CNT_AW'(baddr_r);
      end
      default: begin
        req.ok = 1'b0;
      end
    endcase
  end

  hme_count u_count (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req),
    .clr_en    (state_r == ST_CLEAR),
    .clr_addr  (clr_addr_r),
    .res_valid (out_valid),
    .res       (out_result)
  );

  // every accepted item yields a result on out_valid
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##3 out_valid)
    else $error("accepted item gave no result");

  a_counted_no_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result.pixel_counted) |-> (out_result.count_value == 32'd0))
    else $error("counted pixel carries a count value");

  a_quiet_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !out_valid)
    else $error("result during count store sweep");

endmodule
